[design/ibcs_pkg.sv]
// ----------------------------------------------------------------------------
// IMU calibration package
// Shared constants, state encoding and scale tables.
// ----------------------------------------------------------------------------
`default_nettype none
package ibcs_pkg;
    localparam int BIAS_FRAC_BITS_DEF = 8;
    localparam int OUT_FRAC_BITS_DEF  = 16;
    localparam int NUM_AXES           = 6;

    localparam logic [1:0] REG_ACCEL_RANGE = 2'd0;
    localparam logic [1:0] REG_GYRO_RANGE  = 2'd1;
    localparam logic [1:0] REG_CALIB_COUNT = 2'd2;

    localparam logic ACT_CONVERT = 1'b0;
    localparam logic ACT_CALIB   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_NEXT,
        ST_OUT
    } state_t;

    function automatic logic [14:0] accel_lsb_scale(input logic [1:0] r);
        logic [14:0] s;
        begin
            unique case (r)
                2'd0: s = 15'd16384;
                2'd1: s = 15'd8192;
                2'd2: s = 15'd4096;
                default: s = 15'd2048;
            endcase
            return s;
        end
    endfunction

    function automatic logic [10:0] gyro_scale10(input logic [1:0] r);
        logic [10:0] s;
        begin
            unique case (r)
                2'd0: s = 11'd1310;
                2'd1: s = 11'd655;
                2'd2: s = 11'd328;
                default: s = 11'd164;
            endcase
            return s;
        end
    endfunction
endpackage
`default_nettype wire

[design/imu_bias_calibrate_and_scale_core.sv]
// ----------------------------------------------------------------------------
// IMU bias calibration and scaling core
// Accumulates calibration words, derives biases and scales raw samples.
// ----------------------------------------------------------------------------
// One word is computed at a time. A convert word or the last word of a
// calibration run passes six axes through one restoring divider that
// produces one quotient bit per cycle (QW = 64 quotient bits here). A
// calibration word that does not end a run is only added to the sums, and
// the core stays ready for the next word.
// Results sit in an output register, so the next word is taken while a
// result waits; a second finished result holds the core in its last step
// until the first one is taken.
`default_nettype none
module imu_bias_calibrate_and_scale_core #(
    parameter int BIAS_FRAC_BITS = ibcs_pkg::BIAS_FRAC_BITS_DEF,
    parameter int OUT_FRAC_BITS  = ibcs_pkg::OUT_FRAC_BITS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_action,
    input  wire logic signed [15:0] s_accel_x_raw,
    input  wire logic signed [15:0] s_accel_y_raw,
    input  wire logic signed [15:0] s_accel_z_raw,
    input  wire logic signed [15:0] s_gyro_x_raw,
    input  wire logic signed [15:0] s_gyro_y_raw,
    input  wire logic signed [15:0] s_gyro_z_raw,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_kind,
    output logic signed [31:0]      m_accel_x_out,
    output logic signed [31:0]      m_accel_y_out,
    output logic signed [31:0]      m_accel_z_out,
    output logic signed [31:0]      m_gyro_x_out,
    output logic signed [31:0]      m_gyro_y_out,
    output logic signed [31:0]      m_gyro_z_out
);
    localparam int NW = 64;
    localparam int DW = 32;
    localparam int CW = $clog2(NW + 1);

    ibcs_pkg::state_t state_reg, state_next;

    logic [1:0]  arange_reg, grange_reg;
    logic [15:0] ccount_reg;
    logic signed [31:0] bias_reg [6];
    logic signed [31:0] sum_reg  [6];
    logic [15:0] seen_reg;
    logic signed [15:0] raw_reg [6];
    logic        kind_reg;
    logic [2:0]  axis_reg;
    logic [CW-1:0] cnt_reg;
    logic [NW-1:0] num_reg;
    logic [DW-1:0] den_reg;
    logic [DW:0]   rem_reg;
    logic [NW-1:0] quo_reg;
    logic          neg_reg;
    logic [16:0]   n_reg;
    logic signed [31:0] res_reg [6];
    logic signed [31:0] out_reg [6];
    logic          out_kind_reg;
    logic          out_valid_reg;

    logic [16:0] n_next;
    logic [15:0] target;
    logic signed [63:0] numer;
    logic [DW-1:0] den_sel;
    logic [DW:0] rem_sh, rem_sub;
    logic signed [64:0] q_signed;
    logic signed [64:0] q_adj;
    logic signed [31:0] q_sat;
    logic [14:0] ascale;
    logic [10:0] gscale;
    logic        out_load;

    assign ascale = ibcs_pkg::accel_lsb_scale(arange_reg);
    assign gscale = ibcs_pkg::gyro_scale10(grange_reg);
    assign n_next = {1'b0, seen_reg} + 17'd1;
    assign target = (ccount_reg == 16'd0) ? 16'd1 : ccount_reg;
    assign out_load = (state_reg == ibcs_pkg::ST_OUT) && (!out_valid_reg || m_ready);

    always_comb begin
        logic signed [63:0] r;
        logic signed [63:0] b;
        r = 64'(raw_reg[axis_reg]);
        b = 64'(bias_reg[axis_reg]);
        if (kind_reg) begin
            numer = 64'(sum_reg[axis_reg]) <<< BIAS_FRAC_BITS;
            den_sel = DW'(n_reg);
        end else if (axis_reg < 3'd3) begin
            numer = ((r <<< BIAS_FRAC_BITS) - b) <<< OUT_FRAC_BITS;
            den_sel = DW'({17'd0, ascale} << BIAS_FRAC_BITS);
        end else begin
            numer = (((r <<< BIAS_FRAC_BITS) - b) <<< OUT_FRAC_BITS) * 64'sd10;
            den_sel = DW'({21'd0, gscale} << BIAS_FRAC_BITS);
        end
    end

    assign rem_sh  = {rem_reg[DW-1:0], num_reg[NW-1]};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    always_comb begin
        q_signed = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
        if (neg_reg && rem_reg != '0) q_signed = q_signed - 65'sd1;
        q_adj = q_signed;
        if (kind_reg && axis_reg == 3'd2)
            q_adj = q_signed - (65'(ascale) <<< BIAS_FRAC_BITS);
        if (q_adj > 65'sd2147483647) q_sat = 32'sh7fffffff;
        else if (q_adj < -65'sd2147483648) q_sat = 32'sh80000000;
        else q_sat = q_adj[31:0];
    end

    always_comb begin
        state_next = state_reg;
        s_ready = 1'b0;
        unique case (state_reg)
            ibcs_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid && s_ready) begin
                    if (s_action == ibcs_pkg::ACT_CONVERT || n_next[15:0] >= target)
                        state_next = ibcs_pkg::ST_NEXT;
                end
            end
            ibcs_pkg::ST_NEXT: state_next = ibcs_pkg::ST_DIV;
            ibcs_pkg::ST_DIV: begin
                if (cnt_reg == CW'(NW)) begin
                    state_next = (axis_reg == 3'd5) ? ibcs_pkg::ST_OUT : ibcs_pkg::ST_NEXT;
                end
            end
            ibcs_pkg::ST_OUT: begin
                if (!out_valid_reg || m_ready) state_next = ibcs_pkg::ST_IDLE;
            end
            default: state_next = ibcs_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ibcs_pkg::ST_IDLE;
            arange_reg    <= 2'd0;
            grange_reg    <= 2'd1;
            ccount_reg    <= 16'd1000;
            seen_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 6; i++) begin
                bias_reg[i] <= '0;
                sum_reg[i]  <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    ibcs_pkg::REG_ACCEL_RANGE: arange_reg <= cfg_data[1:0];
                    ibcs_pkg::REG_GYRO_RANGE:  grange_reg <= cfg_data[1:0];
                    ibcs_pkg::REG_CALIB_COUNT: ccount_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (out_load) out_valid_reg <= 1'b1;
            else if (m_ready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                ibcs_pkg::ST_IDLE: begin
                    axis_reg <= '0;
                    if (s_valid && s_ready) begin
                        raw_reg[0] <= s_accel_x_raw;
                        raw_reg[1] <= s_accel_y_raw;
                        raw_reg[2] <= s_accel_z_raw;
                        raw_reg[3] <= s_gyro_x_raw;
                        raw_reg[4] <= s_gyro_y_raw;
                        raw_reg[5] <= s_gyro_z_raw;
                        kind_reg <= s_action;
                        n_reg <= n_next;
                        if (s_action == ibcs_pkg::ACT_CALIB) begin
                            sum_reg[0] <= sum_reg[0] + 32'(s_accel_x_raw);
                            sum_reg[1] <= sum_reg[1] + 32'(s_accel_y_raw);
                            sum_reg[2] <= sum_reg[2] + 32'(s_accel_z_raw);
                            sum_reg[3] <= sum_reg[3] + 32'(s_gyro_x_raw);
                            sum_reg[4] <= sum_reg[4] + 32'(s_gyro_y_raw);
                            sum_reg[5] <= sum_reg[5] + 32'(s_gyro_z_raw);
                            seen_reg <= (n_next[15:0] >= target) ? 16'd0 : n_next[15:0];
                        end
                    end
                end
                ibcs_pkg::ST_NEXT: begin
                    neg_reg <= numer[63];
                    num_reg <= numer[63] ? NW'(-numer) : NW'(numer);
                    den_reg <= den_sel;
                    rem_reg <= '0;
                    quo_reg <= '0;
                    cnt_reg <= '0;
                end
                ibcs_pkg::ST_DIV: begin
                    if (cnt_reg == CW'(NW)) begin
                        res_reg[axis_reg] <= q_sat;
                        if (kind_reg) bias_reg[axis_reg] <= q_sat;
                        axis_reg <= axis_reg + 3'd1;
                    end else begin
                        num_reg <= num_reg << 1;
                        cnt_reg <= cnt_reg + CW'(1);
                        if (!rem_sub[DW]) begin
                            rem_reg <= rem_sub;
                            quo_reg <= {quo_reg[NW-2:0], 1'b1};
                        end else begin
                            rem_reg <= rem_sh;
                            quo_reg <= {quo_reg[NW-2:0], 1'b0};
                        end
                    end
                end
                ibcs_pkg::ST_OUT: begin
                    if (out_load) begin
                        out_kind_reg <= kind_reg;
                        for (int i = 0; i < 6; i++) out_reg[i] <= res_reg[i];
                        if (kind_reg) begin
                            for (int i = 0; i < 6; i++) sum_reg[i] <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_kind        = out_kind_reg;
    assign m_accel_x_out = out_reg[0];
    assign m_accel_y_out = out_reg[1];
    assign m_accel_z_out = out_reg[2];
    assign m_gyro_x_out  = out_reg[3];
    assign m_gyro_y_out  = out_reg[4];
    assign m_gyro_z_out  = out_reg[5];
endmodule
`default_nettype wire

[design/ibcs_checker.sv]
// ----------------------------------------------------------------------------
// IMU calibration port checker
// Watches the ports of the core for handshake slips, unknown bits and valid after reset.
// ----------------------------------------------------------------------------
`default_nettype none
module ibcs_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic        m_kind,
    input wire logic [31:0] m_accel_x_out
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_accel_x_out) && $stable(m_kind))
        else $error("result word changed while stalled");
    a_known: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !$isunknown({m_kind, m_accel_x_out}))
        else $error("result word carries unknown bits");
    a_ctrl_known: assert property (@(posedge aclk) disable iff (!aresetn)
        !$isunknown({s_valid, s_ready, m_valid, m_ready}))
        else $error("handshake signal unknown");
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");
endmodule

bind imu_bias_calibrate_and_scale_core ibcs_checker u_ibcs_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_kind(m_kind),
    .m_accel_x_out(m_accel_x_out)
);
`default_nettype wire
